// ===== hdl/mi3_pkg.sv =====
package mi3_pkg;

  // Entry format
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned LANES  = 9;

  // Exact widths of the intermediate values
  localparam int unsigned PROD_W = 2 * WORD_W;          // entry x entry
  localparam int unsigned ADJ_W  = 2 * WORD_W + 1;      // cofactor
  localparam int unsigned PP_W   = 2 * WORD_W + 1;      // entry x cofactor half
  localparam int unsigned DET_W  = 3 * WORD_W + 3;      // determinant, signed
  localparam int unsigned NUM_W  = ADJ_W + 2 * FRAC_W;  // scaled numerator
  localparam int unsigned REM0_W = NUM_W - WORD_W;      // numerator above the quotient bits

  // Divider: one entry stage plus one stage per quotient bit
  localparam int unsigned DIV_LAT = WORD_W + 1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADJ_W-1:0]  amag_t;
  typedef logic [DET_W-1:0]  dmag_t;

  // Clip a magnitude to the signed word range and apply the sign.
  // Returns {clipped, word}.
  function automatic logic [WORD_W:0] sat_word(word_t q, logic ovf, logic neg);
    word_t lim;
    word_t val;
    logic  sat;
    lim = neg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    sat = ovf | (q > lim);
    val = sat ? lim : q;
    return {sat, (neg ? (~val + 1'b1) : val)};
  endfunction

endpackage

// ===== hdl/matrix3x3_inverse.sv =====
// 3x3 matrix inverse by the adjugate, signed Q16.16 entries.
// Command port: a matrix beat (m11_i..m33_i) is taken at each rising edge
// with start_i high and busy_o low. busy_o is always low: a new matrix may
// be started in every cycle.
// Result port: done_o is high for one cycle with inv11_o..inv33_o,
// determinant_o, singular_o and saturated_o; the beat is taken at the edge
// ending that cycle and there is no way to hold it off.
// Throughput is one matrix per cycle.
// Eight stages (input register, products, cofactors, determinant partial
// products, recombination, determinant sum, magnitude, divisor select)
// feed nine restoring dividers (an entry stage, then one quotient bit per
// stage), then an output stage clips and signs the results.
// A zero determinant makes the divisor one, so the clipped adjugate is
// returned with singular_o set.
// Reset clears the valid pipeline; items in flight are dropped.
module matrix3x3_inverse (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic signed [31:0]     m11_i,
  input  logic signed [31:0]     m12_i,
  input  logic signed [31:0]     m13_i,
  input  logic signed [31:0]     m21_i,
  input  logic signed [31:0]     m22_i,
  input  logic signed [31:0]     m23_i,
  input  logic signed [31:0]     m31_i,
  input  logic signed [31:0]     m32_i,
  input  logic signed [31:0]     m33_i,
  output logic                   done_o,
  output logic signed [31:0]     inv11_o,
  output logic signed [31:0]     inv12_o,
  output logic signed [31:0]     inv13_o,
  output logic signed [31:0]     inv21_o,
  output logic signed [31:0]     inv22_o,
  output logic signed [31:0]     inv23_o,
  output logic signed [31:0]     inv31_o,
  output logic signed [31:0]     inv32_o,
  output logic signed [31:0]     inv33_o,
  output logic signed [31:0]     determinant_o,
  output logic                   singular_o,
  output logic                   saturated_o
);

  localparam int unsigned W   = mi3_pkg::WORD_W;
  localparam int unsigned F   = mi3_pkg::FRAC_W;
  localparam int unsigned AW  = mi3_pkg::ADJ_W;
  localparam int unsigned DW  = mi3_pkg::DET_W;
  localparam int unsigned PW  = mi3_pkg::PROD_W;
  localparam int unsigned PPW = mi3_pkg::PP_W;
  localparam int unsigned NL  = mi3_pkg::LANES;
  localparam int unsigned DL  = mi3_pkg::DIV_LAT;
  localparam int unsigned NV  = W + 10;

  // Cofactor i = m[PA[2i]]*m[PB[2i]] - m[PA[2i+1]]*m[PB[2i+1]], transposed
  localparam int PA [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int PB [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};
  // Cofactors of the first row used for the determinant
  localparam int DI [3]  = '{0, 3, 6};

  logic [NV-1:0] vld_q;

  logic signed [W-1:0]   m_q    [NL];
  logic signed [PW-1:0]  prod_q [18];
  logic signed [W-1:0]   mb_q   [3];
  logic signed [AW-1:0]  adj_q  [NL];
  logic signed [W-1:0]   mc_q   [3];
  logic signed [PPW-1:0] plo_q  [3];
  logic signed [PPW-1:0] phi_q  [3];
  mi3_pkg::amag_t        amag_q [5][NL];
  logic                  aneg_q [4][NL];
  logic signed [DW-1:0]  term_q [3];
  logic signed [DW-1:0]  det_q;
  logic                  sing_g_q;
  logic                  dneg_g_q;
  mi3_pkg::dmag_t        dmag_g_q;
  mi3_pkg::dmag_t        dvs_q;
  mi3_pkg::word_t        detw_c;
  logic                  dsat_c;

  // Side band travelling alongside the dividers
  logic                  qneg_q [DL][NL];
  mi3_pkg::word_t        detw_q [DL];
  logic                  dsat_q [DL];
  logic                  sing_q [DL];

  mi3_pkg::word_t        quo    [NL];
  logic [NL-1:0]         ovf;

  logic signed [W-1:0]   inv_q  [NL];
  logic signed [W-1:0]   detout_q;
  logic                  sing_out_q;
  logic                  sat_out_q;

  assign busy_o = 1'b0;

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NV-2:0], start_i & ~busy_o};
    end
  end

  // Input beat register
  always_ff @(posedge clk_i) begin
    m_q[0] <= m11_i;
    m_q[1] <= m12_i;
    m_q[2] <= m13_i;
    m_q[3] <= m21_i;
    m_q[4] <= m22_i;
    m_q[5] <= m23_i;
    m_q[6] <= m31_i;
    m_q[7] <= m32_i;
    m_q[8] <= m33_i;
  end

  // Products of entry pairs
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 18; j++) begin
      prod_q[j] <= m_q[PA[j]] * m_q[PB[j]];
    end
    for (int k = 0; k < 3; k++) begin
      mb_q[k] <= m_q[k];
    end
  end

  // Adjugate entries
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NL; i++) begin
      adj_q[i] <= AW'(prod_q[2*i]) - AW'(prod_q[2*i+1]);
    end
    for (int k = 0; k < 3; k++) begin
      mc_q[k] <= mb_q[k];
    end
  end

  // Determinant partial products (cofactor split into halves), magnitudes
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      plo_q[k] <= mc_q[k] * $signed({1'b0, adj_q[DI[k]][W-1:0]});
      phi_q[k] <= mc_q[k] * $signed(adj_q[DI[k]][AW-1:W]);
    end
    for (int i = 0; i < NL; i++) begin
      amag_q[0][i] <= adj_q[i][AW-1] ? AW'(-adj_q[i]) : AW'(adj_q[i]);
      aneg_q[0][i] <= adj_q[i][AW-1];
    end
  end

  // Adjugate magnitudes and signs wait for the divisor
  always_ff @(posedge clk_i) begin
    for (int s = 1; s < 5; s++) begin
      amag_q[s] <= amag_q[s-1];
    end
    for (int s = 1; s < 4; s++) begin
      aneg_q[s] <= aneg_q[s-1];
    end
  end

  // Recombine halves
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      term_q[k] <= (DW'(phi_q[k]) <<< W) + DW'(plo_q[k]);
    end
  end

  // Determinant sum
  always_ff @(posedge clk_i) begin
    det_q <= term_q[0] + term_q[1] + term_q[2];
  end

  // Zero test and magnitude
  always_ff @(posedge clk_i) begin
    sing_g_q <= (det_q == '0);
    dneg_g_q <= det_q[DW-1];
    dmag_g_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
  end

  // Divisor select, determinant word, quotient signs
  always_comb begin
    mi3_pkg::dmag_t dsh;
    dsh = dmag_g_q >> (2 * F);
    {dsat_c, detw_c} = mi3_pkg::sat_word(dsh[W-1:0], |dsh[DW-1:W], dneg_g_q);
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= sing_g_q ? (DW'(1) << (3 * F)) : dmag_g_q;
  end

  // Side band: first element is loaded in step with the dividers' entry
  logic                  qneg_h_q [NL];
  mi3_pkg::word_t        detw_h_q;
  logic                  dsat_h_q;
  logic                  sing_h_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NL; i++) begin
      qneg_h_q[i] <= aneg_q[3][i] ^ (dneg_g_q & ~sing_g_q);
    end
    detw_h_q <= detw_c;
    dsat_h_q <= dsat_c;
    sing_h_q <= sing_g_q;
  end

  always_ff @(posedge clk_i) begin
    qneg_q[0] <= qneg_h_q;
    sing_q[0] <= sing_h_q;
    detw_q[0] <= detw_h_q;
    dsat_q[0] <= dsat_h_q;
    for (int s = 1; s < DL; s++) begin
      qneg_q[s] <= qneg_q[s-1];
      sing_q[s] <= sing_q[s-1];
      detw_q[s] <= detw_q[s-1];
      dsat_q[s] <= dsat_q[s-1];
    end
  end

  mi3_div u_div (
    .clk_i  (clk_i),
    .amag_i (amag_q[4]),
    .dvs_i  (dvs_q),
    .quo_o  (quo),
    .ovf_o  (ovf)
  );

  // Output stage: clip, sign, gather flags
  always_ff @(posedge clk_i) begin
    logic [NL-1:0]  lsat;
    logic [W:0]     pk;
    lsat = '0;
    for (int i = 0; i < NL; i++) begin
      pk       = mi3_pkg::sat_word(quo[i], ovf[i], qneg_q[DL-1][i]);
      lsat[i]  = pk[W];
      inv_q[i] <= $signed(pk[W-1:0]);
    end
    detout_q   <= $signed(detw_q[DL-1]);
    sing_out_q <= sing_q[DL-1];
    sat_out_q  <= (|lsat) | dsat_q[DL-1];
  end

  assign done_o        = vld_q[NV-1];
  assign inv11_o       = inv_q[0];
  assign inv12_o       = inv_q[1];
  assign inv13_o       = inv_q[2];
  assign inv21_o       = inv_q[3];
  assign inv22_o       = inv_q[4];
  assign inv23_o       = inv_q[5];
  assign inv31_o       = inv_q[6];
  assign inv32_o       = inv_q[7];
  assign inv33_o       = inv_q[8];
  assign determinant_o = detout_q;
  assign singular_o    = sing_out_q;
  assign saturated_o   = sat_out_q;

  // A beat in the divisor select stage raises done_o once it has passed the dividers and the output stage
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] |-> ##(W + 2) done_o)
    else $error("result strobe out of step with pipeline");

  // A singular matrix has a zero determinant word
  a_sing_det : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && singular_o) |-> (determinant_o == '0))
    else $error("singular result with nonzero determinant");

  // Any divider overflow must raise the clip flag
  a_ovf_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NV-2] && (|ovf)) |=> saturated_o)
    else $error("quotient overflow without saturation flag");

endmodule

// ===== hdl/mi3_div.sv =====
// Nine restoring dividers sharing one divisor pipeline.
// Quotient = (amag << 2*FRAC_W) / dvs, WORD_W bits, with an overflow flag
// when the quotient does not fit. One quotient bit per stage.
module mi3_div (
  input  logic                 clk_i,
  input  mi3_pkg::amag_t       amag_i [mi3_pkg::LANES],
  input  mi3_pkg::dmag_t       dvs_i,
  output mi3_pkg::word_t       quo_o  [mi3_pkg::LANES],
  output logic [mi3_pkg::LANES-1:0] ovf_o
);

  localparam int unsigned W  = mi3_pkg::WORD_W;
  localparam int unsigned DW = mi3_pkg::DET_W;
  localparam int unsigned NL = mi3_pkg::LANES;

  logic [DW-1:0] rem_q [W][NL];
  logic [W-1:0]  nlo_q [W][NL];
  logic [DW-1:0] d_q   [W];
  logic [W-1:0]  quo_q [W+1][NL];
  logic          ovf_q [W+1][NL];

  // Entry stage: split the scaled numerator, flag quotients that overflow
  for (genvar i = 0; i < NL; i++) begin : g_entry
    logic [mi3_pkg::NUM_W-1:0]  num;
    logic [mi3_pkg::REM0_W-1:0] hi;
    logic [DW-1:0]              hi_ext;
    assign num    = {amag_i[i], {(2 * mi3_pkg::FRAC_W){1'b0}}};
    assign hi     = num[mi3_pkg::NUM_W-1:W];
    assign hi_ext = DW'(hi);
    always_ff @(posedge clk_i) begin
      rem_q[0][i] <= hi_ext;
      nlo_q[0][i] <= num[W-1:0];
      ovf_q[0][i] <= (hi_ext >= dvs_i);
      quo_q[0][i] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q[0] <= dvs_i;
  end

  // One compare-subtract per stage and lane
  for (genvar k = 1; k <= W; k++) begin : g_stage
    for (genvar i = 0; i < NL; i++) begin : g_lane
      logic [DW:0] sh;
      logic [DW:0] diff;
      logic        ge;
      assign sh   = {rem_q[k-1][i], nlo_q[k-1][i][W-1]};
      assign diff = sh - {1'b0, d_q[k-1]};
      assign ge   = (sh >= {1'b0, d_q[k-1]});
      always_ff @(posedge clk_i) begin
        quo_q[k][i] <= {quo_q[k-1][i][W-2:0], ge};
        ovf_q[k][i] <= ovf_q[k-1][i];
      end
      if (k < W) begin : g_carry
        always_ff @(posedge clk_i) begin
          rem_q[k][i] <= ge ? diff[DW-1:0] : sh[DW-1:0];
          nlo_q[k][i] <= nlo_q[k-1][i] << 1;
        end
      end
    end
    if (k < W) begin : g_dvs
      always_ff @(posedge clk_i) begin
        d_q[k] <= d_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < NL; i++) begin : g_out
    assign quo_o[i] = quo_q[W][i];
    assign ovf_o[i] = ovf_q[W][i];
  end

endmodule
